// File: src/ptma_pkg.sv
// Shared constants, codes and types for the page table map and allocate block.
package ptma_pkg;

  localparam int PROCESSES_DEF  = 3;
  localparam int ENTRIES_DEF    = 4096;
  localparam int PHYS_PAGES_DEF = 4096;

  localparam int PROC_W  = 2;
  localparam int VPAGE_W = 20;
  localparam int FRAME_W = 12;
  localparam int CFG_W   = 13;
  localparam int CNT_W   = 32;
  localparam int USED_W  = 13;

  localparam logic [CFG_W-1:0] TOTAL_RESET  = 13'd4096;
  localparam logic [CFG_W-1:0] SYSTEM_RESET = 13'd0;

  typedef enum logic {
    REG_TOTAL  = 1'b0,
    REG_SYSTEM = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    OUT_HIT    = 2'd0,
    OUT_MAPPED = 2'd1,
    OUT_FAULT  = 2'd2,
    OUT_RANGE  = 2'd3
  } outcome_t;

  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  typedef struct packed {
    logic             avail;
    logic [CFG_W-1:0] page;
  } pool_status_t;

endpackage

// File: src/ptma_table.sv
// Page table memory: registered read, write-back forwarding, clearing sweep after reset.
module ptma_table #(
  parameter int DEPTH = ptma_pkg::PROCESSES_DEF * ptma_pkg::ENTRIES_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ADDR_W-1:0]   rd_addr,
  output ptma_pkg::entry_t    rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  ptma_pkg::entry_t    wr_data,
  output logic                clearing
);

  ptma_pkg::entry_t mem [DEPTH];

  logic [ADDR_W-1:0] clr_addr;
  logic              clr_active;
  logic [ADDR_W-1:0] rd_addr_q;
  ptma_pkg::entry_t  rd_q;
  logic              fwd_en;
  logic [ADDR_W-1:0] fwd_addr;
  ptma_pkg::entry_t  fwd_data;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  ptma_pkg::entry_t  mem_din;

  always_comb begin
    if (clr_active) begin
      mem_we   = 1'b1;
      mem_addr = clr_addr;
      mem_din  = '0;
    end else begin
      mem_we   = wr_en;
      mem_addr = wr_addr;
      mem_din  = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_din;
    end
    rd_q      <= mem[rd_addr];
    rd_addr_q <= rd_addr;
    fwd_addr  <= wr_addr;
    fwd_data  <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
      fwd_en     <= 1'b0;
    end else begin
      fwd_en <= wr_en && !clr_active;
      if (clr_active) begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          clr_active <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
    end
  end

  // a read issued in the same cycle as a write to that entry sees the new word
  assign rd_data  = (fwd_en && (fwd_addr == rd_addr_q)) ? fwd_data : rd_q;
  assign clearing = clr_active;

endmodule

// File: src/ptma_pool.sv
// Free page pool: configuration registers and the highest-first page pointer.
module ptma_pool #(
  parameter int PHYS_PAGES = ptma_pkg::PHYS_PAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [ptma_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         take,
  output ptma_pkg::pool_status_t       status
);

  localparam int CFG_W = ptma_pkg::CFG_W;
  localparam int RESET_EFF = (int'(ptma_pkg::TOTAL_RESET) > PHYS_PAGES) ?
                             PHYS_PAGES : int'(ptma_pkg::TOTAL_RESET);

  logic [CFG_W-1:0] total_pages;
  logic [CFG_W-1:0] system_pages;
  logic [CFG_W-1:0] free_next;
  logic             pool_empty;

  logic [CFG_W-1:0] total_new;
  logic [CFG_W-1:0] system_new;
  logic [CFG_W-1:0] eff;

  always_comb begin
    total_new  = total_pages;
    system_new = system_pages;
    if (cfg_index == ptma_pkg::REG_TOTAL) begin
      total_new = cfg_data;
    end else begin
      system_new = cfg_data;
    end
    // totals beyond the physical memory are clipped to it
    if (32'(total_new) > 32'(PHYS_PAGES)) begin
      eff = CFG_W'(PHYS_PAGES);
    end else begin
      eff = total_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages  <= ptma_pkg::TOTAL_RESET;
      system_pages <= ptma_pkg::SYSTEM_RESET;
      free_next    <= (RESET_EFF == 0) ? '0 : CFG_W'(RESET_EFF - 1);
      pool_empty   <= (RESET_EFF == 0);
    end else if (cfg_write) begin
      total_pages  <= total_new;
      system_pages <= system_new;
      free_next    <= (eff == '0) ? '0 : eff - 1'b1;
      pool_empty   <= (eff == '0);
    end else if (take) begin
      if ((free_next == '0) || (free_next == system_pages)) begin
        pool_empty <= 1'b1;
      end else begin
        free_next <= free_next - 1'b1;
      end
    end
  end

  assign status.avail = !pool_empty && (free_next >= system_pages);
  assign status.page  = free_next;

endmodule

// File: src/page_table_map_allocate.sv
// Page table lookup with free page allocation: one item a cycle while busy is low, ready after a clearing sweep.
// An accepted item is registered in s1 with its table read, then in the result registers and done.
// One item every cycle while busy is low; a table read at acceptance, a read-modify-write of the
// entry in the next cycle, with the last write forwarded when the next item hits the same entry.
// Reset: rst (synchronous) clears control state and counters and refills the free pool, then a
// clearing sweep zeroes the table one entry a cycle, with busy high. Configuration writes are
// taken at any time; results cannot stall.
module page_table_map_allocate #(
  parameter int PROCESSES           = ptma_pkg::PROCESSES_DEF,
  parameter int ENTRIES_PER_PROCESS = ptma_pkg::ENTRIES_DEF,
  parameter int PHYS_PAGES          = ptma_pkg::PHYS_PAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // item in
  input  logic                          start,
  output logic                          busy,
  input  logic [ptma_pkg::PROC_W-1:0]   process,
  input  logic [ptma_pkg::VPAGE_W-1:0]  virtual_page,
  // register writes
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [ptma_pkg::CFG_W-1:0]    cfg_data,
  // result out
  output logic                          done,
  output logic [1:0]                    outcome,
  output logic [ptma_pkg::FRAME_W-1:0]  physical_page,
  output logic [ptma_pkg::CNT_W-1:0]    hit_count,
  output logic [ptma_pkg::CNT_W-1:0]    alloc_count,
  output logic [ptma_pkg::CNT_W-1:0]    fault_count,
  output logic [ptma_pkg::CNT_W-1:0]    mapped_count,
  output logic [ptma_pkg::USED_W-1:0]   used_entries
);

  localparam int DEPTH   = PROCESSES * ENTRIES_PER_PROCESS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int PIDX_W  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int CNT_W   = ptma_pkg::CNT_W;
  localparam int USED_W  = ptma_pkg::USED_W;
  localparam int FRAME_W = ptma_pkg::FRAME_W;

  logic accept;
  logic clearing;

  // table address: process base plus page; only written for in-range items
  logic [ADDR_W-1:0] rd_addr;
  logic              proc_ok;
  logic              page_ok;

  // lookup stage, filled at acceptance
  logic                        s1_valid;
  logic                        s1_proc_ok;
  logic                        s1_page_ok;
  logic [ADDR_W-1:0]           s1_addr;
  logic [ptma_pkg::PROC_W-1:0] s1_proc;

  ptma_pkg::entry_t       entry;
  ptma_pkg::entry_t       wr_data;
  ptma_pkg::pool_status_t pool;

  logic hit;
  logic miss;
  logic take;

  // running totals
  logic [CNT_W-1:0]  hits;
  logic [CNT_W-1:0]  allocs;
  logic [CNT_W-1:0]  faults;
  logic [CNT_W-1:0]  attempts;
  logic [USED_W-1:0] used [PROCESSES];

  logic [PIDX_W-1:0] pidx;
  logic [USED_W-1:0] used_cur;
  logic [USED_W-1:0] used_inc;

  ptma_pkg::outcome_t     outcome_next;
  ptma_pkg::outcome_t     outcome_reg;
  logic [FRAME_W-1:0]     physical_page_next;
  logic [USED_W-1:0]      used_entries_next;

  assign busy   = clearing;
  assign accept = start && !busy;

  assign proc_ok = 32'(process) < 32'(PROCESSES);
  assign page_ok = 32'(virtual_page) < 32'(ENTRIES_PER_PROCESS);
  assign rd_addr = ADDR_W'(ADDR_W'(process) * ADDR_W'(ENTRIES_PER_PROCESS)
                           + ADDR_W'(virtual_page));

  ptma_table #(
    .DEPTH (DEPTH)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .rd_data  (entry),
    .wr_en    (take),
    .wr_addr  (s1_addr),
    .wr_data  (wr_data),
    .clearing (clearing)
  );

  ptma_pool #(
    .PHYS_PAGES (PHYS_PAGES)
  ) u_pool (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .status    (pool)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_proc_ok <= proc_ok;
      s1_page_ok <= page_ok;
      s1_addr    <= rd_addr;
      s1_proc    <= process;
    end
  end

  // decision on the word just read
  assign hit  = s1_valid && s1_proc_ok && s1_page_ok && entry.valid;
  assign miss = s1_valid && s1_proc_ok && s1_page_ok && !entry.valid;
  assign take = miss && pool.avail;

  assign wr_data.valid = 1'b1;
  assign wr_data.frame = pool.page[FRAME_W-1:0];

  assign pidx     = PIDX_W'(s1_proc);
  assign used_cur = used[pidx];
  assign used_inc = (used_cur == '1) ? used_cur : used_cur + 1'b1;

  always_comb begin
    outcome_next       = ptma_pkg::OUT_RANGE;
    physical_page_next = '0;
    used_entries_next  = '0;
    if (hit) begin
      outcome_next       = ptma_pkg::OUT_HIT;
      physical_page_next = entry.frame;
    end else if (take) begin
      outcome_next       = ptma_pkg::OUT_MAPPED;
      physical_page_next = pool.page[FRAME_W-1:0];
    end else if (miss) begin
      outcome_next = ptma_pkg::OUT_FAULT;
    end
    if (s1_proc_ok) begin
      used_entries_next = take ? used_inc : used_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits     <= '0;
      allocs   <= '0;
      faults   <= '0;
      attempts <= '0;
      for (int p = 0; p < PROCESSES; p++) begin
        used[p] <= '0;
      end
      done <= 1'b0;
    end else begin
      done <= s1_valid;
      if (hit && (hits != '1)) begin
        hits <= hits + 1'b1;
      end
      if (miss && (attempts != '1)) begin
        attempts <= attempts + 1'b1;
      end
      if (take && (allocs != '1)) begin
        allocs <= allocs + 1'b1;
      end
      if (miss && !take && (faults != '1)) begin
        faults <= faults + 1'b1;
      end
      if (take) begin
        used[pidx] <= used_inc;
      end
    end
    if (s1_valid) begin
      outcome_reg   <= outcome_next;
      physical_page <= physical_page_next;
      used_entries  <= used_entries_next;
    end
  end

  // totals move only on a step, so they stand for the result in the strobe cycle
  assign outcome      = outcome_reg;
  assign hit_count    = hits;
  assign alloc_count  = allocs;
  assign fault_count  = faults;
  assign mapped_count = attempts;

endmodule

// File: test/tb_page_table_map_allocate.sv
// Self-checking bench for the page table lookup and free page allocation block.
module tb_page_table_map_allocate;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PROC_W         = ptma_pkg::PROC_W;
  localparam int VPAGE_W        = ptma_pkg::VPAGE_W;
  localparam int CFG_W          = ptma_pkg::CFG_W;
  localparam int FRAME_W        = ptma_pkg::FRAME_W;
  localparam int CNT_W          = ptma_pkg::CNT_W;
  localparam int USED_W         = ptma_pkg::USED_W;
  localparam int PROCESSES_DEF  = ptma_pkg::PROCESSES_DEF;
  localparam int ENTRIES_DEF    = ptma_pkg::ENTRIES_DEF;
  localparam int PHYS_PAGES_DEF = ptma_pkg::PHYS_PAGES_DEF;

  typedef ptma_pkg::outcome_t   outcome_t;
  typedef ptma_pkg::reg_index_t reg_index_t;

  // Random part length, counted in items sent after the directed plan.
  localparam int RANDOM_ITEMS   = 1025;
  // Quiet tail: the last items go in with no sender gaps at all.
  localparam int TAIL_ITEMS     = 150;
  // Longest stretch without an accepted item: covers the clearing sweep after
  // reset with a wide margin.
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int TABLE_DEPTH    = PROCESSES_DEF * ENTRIES_DEF;

  // ---------------------------------------------------------------------------
  // DUT hook-up
  // ---------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [PROC_W-1:0]   process;
  logic [VPAGE_W-1:0]  virtual_page;
  logic                cfg_write;
  logic                cfg_index;
  logic [CFG_W-1:0]    cfg_data;
  logic                done;
  logic [1:0]          outcome;
  logic [FRAME_W-1:0]  physical_page;
  logic [CNT_W-1:0]    hit_count;
  logic [CNT_W-1:0]    alloc_count;
  logic [CNT_W-1:0]    fault_count;
  logic [CNT_W-1:0]    mapped_count;
  logic [USED_W-1:0]   used_entries;

  page_table_map_allocate u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .process       (process),
    .virtual_page  (virtual_page),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .outcome       (outcome),
    .physical_page (physical_page),
    .hit_count     (hit_count),
    .alloc_count   (alloc_count),
    .fault_count   (fault_count),
    .mapped_count  (mapped_count),
    .used_entries  (used_entries)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Page table shadow: mirrors the block's tables, free pool and totals
  // ---------------------------------------------------------------------------
  typedef struct {
    outcome_t           outc;
    logic [FRAME_W-1:0] page;
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   allocs;
    logic [CNT_W-1:0]   faults;
    logic [CNT_W-1:0]   attempts;
    logic [USED_W-1:0]  used;
  } access_result_t;

  bit                 map_valid [TABLE_DEPTH];
  logic [FRAME_W-1:0] map_frame [TABLE_DEPTH];
  logic [CFG_W-1:0]   next_free;
  bit                 pool_dry;
  logic [CNT_W-1:0]   n_hits, n_allocs, n_faults, n_attempts;
  logic [USED_W-1:0]  n_used [PROCESSES_DEF];
  logic [CFG_W-1:0]   pg_total  = ptma_pkg::TOTAL_RESET;
  logic [CFG_W-1:0]   pg_system = ptma_pkg::SYSTEM_RESET;

  // Results owed by the block, oldest first.
  access_result_t     due_results [$];
  int                 mismatches = 0;
  int                 quiet_cycles = 0;

  // Any register write restarts the pool at the top of the effective total;
  // a total above the physical page count is clipped to it.
  function automatic void refill_pool();
    logic [CFG_W-1:0] eff;
    eff = (pg_total > CFG_W'(PHYS_PAGES_DEF)) ? CFG_W'(PHYS_PAGES_DEF) : pg_total;
    pool_dry  = (eff == '0);
    next_free = pool_dry ? '0 : eff - 1'b1;
  endfunction

  // One access: hit, fresh mapping from the pool, fault, or out of range.
  function automatic access_result_t look_up_page(input logic [PROC_W-1:0] p,
                                                  input logic [VPAGE_W-1:0] v);
    access_result_t r;
    int             slot;
    r.outc = ptma_pkg::OUT_RANGE;
    r.page = '0;
    r.used = '0;
    if (p < PROCESSES_DEF) begin
      if (v < ENTRIES_DEF) begin
        slot = int'(p) * ENTRIES_DEF + int'(v);
        if (map_valid[slot]) begin
          if (n_hits != '1) n_hits++;
          r.outc = ptma_pkg::OUT_HIT;
          r.page = map_frame[slot];
        end else begin
          if (n_attempts != '1) n_attempts++;
          if (!pool_dry && next_free >= pg_system) begin
            r.page = next_free[FRAME_W-1:0];
            // pool runs dry once page 0 or the lowest unreserved page goes
            if (next_free == '0 || next_free == pg_system) pool_dry = 1'b1;
            else next_free--;
            map_valid[slot] = 1'b1;
            map_frame[slot] = r.page;
            if (n_used[p] != '1) n_used[p]++;
            if (n_allocs != '1) n_allocs++;
            r.outc = ptma_pkg::OUT_MAPPED;
          end else begin
            if (n_faults != '1) n_faults++;
            r.outc = ptma_pkg::OUT_FAULT;
          end
        end
      end
      r.used = n_used[p];
    end
    r.hits     = n_hits;
    r.allocs   = n_allocs;
    r.faults   = n_faults;
    r.attempts = n_attempts;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // start is left high on acceptance; whoever comes next decides whether it
  // stays up, so it never sees two assignments in one step.
  task automatic send_item(input logic [PROC_W-1:0] p, input logic [VPAGE_W-1:0] v,
                           input bit typed, input outcome_t outc,
                           input logic [FRAME_W-1:0] page);
    access_result_t r;
    start        <= 1'b1;
    process      <= p;
    virtual_page <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = look_up_page(p, v);
    // rows with a hand-written answer override the shadow's outcome and page
    if (typed) begin
      r.outc = outc;
      r.page = page;
    end
    due_results.insert(due_results.size(), r);
  endtask

  task automatic sender_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Registers change only with the pipe empty; a few spare cycles let the
  // last table write settle first.
  task automatic write_reg(input reg_index_t sel, input logic [CFG_W-1:0] value);
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    if (sel == ptma_pkg::REG_TOTAL) pg_total = value;
    else pg_system = value;
    refill_pool();
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed plan
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {
    ROW_ITEM,   // item, answer from the shadow
    ROW_TYPED,  // item, outcome and page written in below
    ROW_CFG     // register write, value in arg
  } row_kind_t;

  typedef struct {
    row_kind_t          kind;
    reg_index_t         sel;
    logic [PROC_W-1:0]  proc;
    logic [VPAGE_W-1:0] arg;
    outcome_t           outc;
    logic [FRAME_W-1:0] page;
  } plan_row_t;

  localparam int PLAN_ROWS = 33;

  plan_row_t plan [PLAN_ROWS] = '{
    // fresh tables, full pool handed out from 4095 down
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd0, 20'd0,     ptma_pkg::OUT_MAPPED, 12'd4095},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd0, 20'd0,     ptma_pkg::OUT_HIT,    12'd4095},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd0, 20'd4095,  ptma_pkg::OUT_MAPPED, 12'd4094},
    // page just past the table, and the largest page number
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd0, 20'd4096,  ptma_pkg::OUT_RANGE,  12'd0},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd0, 20'hFFFFF, ptma_pkg::OUT_RANGE,  12'd0},
    // no table behind process 3
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd3, 20'd0,     ptma_pkg::OUT_RANGE,  12'd0},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd3, 20'hFFFFF, ptma_pkg::OUT_RANGE,  12'd0},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd2, 20'd4095,  ptma_pkg::OUT_MAPPED, 12'd4093},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd1, 20'd0,     ptma_pkg::OUT_MAPPED, 12'd4092},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd2, 20'd4095,  ptma_pkg::OUT_HIT,    12'd4093},
    '{ROW_ITEM,  ptma_pkg::REG_TOTAL,  2'd1, 20'h00AAA, ptma_pkg::OUT_HIT,    12'd0},
    '{ROW_ITEM,  ptma_pkg::REG_TOTAL,  2'd1, 20'h00555, ptma_pkg::OUT_HIT,    12'd0},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd3, 20'hAAAAA, ptma_pkg::OUT_RANGE,  12'd0},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd2, 20'h55555, ptma_pkg::OUT_RANGE,  12'd0},
    // two-page pool: runs out at page 0, then the miss keeps faulting
    '{ROW_CFG,   ptma_pkg::REG_TOTAL,  2'd0, 20'd2,     ptma_pkg::OUT_HIT,    12'd0},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd0, 20'd1,     ptma_pkg::OUT_MAPPED, 12'd1},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd0, 20'd2,     ptma_pkg::OUT_MAPPED, 12'd0},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd0, 20'd3,     ptma_pkg::OUT_FAULT,  12'd0},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd0, 20'd3,     ptma_pkg::OUT_FAULT,  12'd0},
    // zero total: empty pool
    '{ROW_CFG,   ptma_pkg::REG_TOTAL,  2'd0, 20'd0,     ptma_pkg::OUT_HIT,    12'd0},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd1, 20'd7,     ptma_pkg::OUT_FAULT,  12'd0},
    // oversized total clipped to 4096, reserve leaves just the top page
    '{ROW_CFG,   ptma_pkg::REG_TOTAL,  2'd0, 20'd8191,  ptma_pkg::OUT_HIT,    12'd0},
    '{ROW_CFG,   ptma_pkg::REG_SYSTEM, 2'd0, 20'd4095,  ptma_pkg::OUT_HIT,    12'd0},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd2, 20'd9,     ptma_pkg::OUT_MAPPED, 12'd4095},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd2, 20'd10,    ptma_pkg::OUT_FAULT,  12'd0},
    // reserve at or above the total
    '{ROW_CFG,   ptma_pkg::REG_SYSTEM, 2'd0, 20'd8191,  ptma_pkg::OUT_HIT,    12'd0},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd1, 20'd8,     ptma_pkg::OUT_FAULT,  12'd0},
    '{ROW_CFG,   ptma_pkg::REG_SYSTEM, 2'd0, 20'd4096,  ptma_pkg::OUT_HIT,    12'd0},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd1, 20'd8,     ptma_pkg::OUT_FAULT,  12'd0},
    // back to defaults: earlier mappings survive the pool reload
    '{ROW_CFG,   ptma_pkg::REG_SYSTEM, 2'd0, 20'd0,     ptma_pkg::OUT_HIT,    12'd0},
    '{ROW_CFG,   ptma_pkg::REG_TOTAL,  2'd0, 20'd4096,  ptma_pkg::OUT_HIT,    12'd0},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd0, 20'd0,     ptma_pkg::OUT_HIT,    12'd4095},
    '{ROW_TYPED, ptma_pkg::REG_TOTAL,  2'd0, 20'd1,     ptma_pkg::OUT_HIT,    12'd1}
  };

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [PROC_W-1:0]  p;
    logic [VPAGE_W-1:0] v;
    logic [CFG_W-1:0]   tot, sys;
    int                 items_sent;
    int                 phase_len;
    bit                 gappy;

    rst          <= 1'b1;
    start        <= 1'b0;
    process      <= '0;
    virtual_page <= '0;
    cfg_write    <= 1'b0;
    cfg_index    <= ptma_pkg::REG_TOTAL;
    cfg_data     <= '0;

    n_hits     = '0;
    n_allocs   = '0;
    n_faults   = '0;
    n_attempts = '0;
    foreach (n_used[i]) n_used[i] = '0;
    foreach (map_valid[i]) map_valid[i] = 1'b0;
    refill_pool();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed plan; the first item simply waits out the clearing sweep
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        write_reg(plan[i].sel, plan[i].arg[CFG_W-1:0]);
      else
        send_item(plan[i].proc, plan[i].arg, plan[i].kind == ROW_TYPED,
                  plan[i].outc, plan[i].page);
    end

    // random phases, each under a fresh pool setting
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 11))
        0: begin tot = 13'd4096; sys = 13'd0; end
        1: begin tot = 13'd8191; sys = 13'($urandom_range(4080, 4095)); end
        2: begin tot = 13'd0;    sys = 13'd0; end
        3: begin tot = 13'd1;    sys = 13'd0; end
        4: begin
          tot = 13'($urandom_range(1, 64));
          sys = tot + 13'($urandom_range(0, 8));
        end
        5: begin tot = 13'($urandom()); sys = 13'($urandom()); end
        default: begin
          tot = 13'($urandom_range(2, 80));
          sys = ($urandom_range(0, 2) == 0) ? 13'd0 : 13'($urandom_range(0, tot - 1));
        end
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(ptma_pkg::REG_TOTAL, tot);
        write_reg(ptma_pkg::REG_SYSTEM, sys);
      end else begin
        write_reg(ptma_pkg::REG_SYSTEM, sys);
        write_reg(ptma_pkg::REG_TOTAL, tot);
      end

      gappy     = ($urandom_range(0, 2) != 0);
      phase_len = $urandom_range(60, 110);
      for (int k = 0; k < phase_len && items_sent < RANDOM_ITEMS; k++) begin
        p = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        // small working set for hits and repeated faults, the rest spread out
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: v = 20'($urandom_range(0, 47));
          11, 12, 13, 14, 15:               v = 20'($urandom_range(0, 4095));
          16, 17:                           v = 20'($urandom_range(4096, 20'hFFFFF));
          default:                          v = 20'($urandom());
        endcase
        if (gappy && items_sent < RANDOM_ITEMS - TAIL_ITEMS &&
            $urandom_range(0, 4) == 0)
          sender_gap($urandom_range(1, 19));
        send_item(p, v, 1'b0, ptma_pkg::OUT_HIT, '0);
        items_sent++;
      end
    end

    // drain, then a few spare cycles to catch stray strobes
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result check and watchdog
  // ---------------------------------------------------------------------------
  function automatic void note_mismatch(input string what, input longint unsigned want_v,
                                        input longint unsigned got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want_v, got_v);
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    if (!rst && done) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing due, outcome %0d page %0d",
                   $realtime, outcome, physical_page);
      end else begin
        want = due_results.pop_front();
        if (outcome != want.outc)          note_mismatch("outcome", want.outc, outcome);
        if (physical_page != want.page)    note_mismatch("physical_page", want.page,
                                                         physical_page);
        if (hit_count != want.hits)        note_mismatch("hit_count", want.hits, hit_count);
        if (alloc_count != want.allocs)    note_mismatch("alloc_count", want.allocs,
                                                         alloc_count);
        if (fault_count != want.faults)    note_mismatch("fault_count", want.faults,
                                                         fault_count);
        if (mapped_count != want.attempts) note_mismatch("mapped_count", want.attempts,
                                                         mapped_count);
        if (used_entries != want.used)     note_mismatch("used_entries", want.used,
                                                         used_entries);
      end
    end
  end

  // counts cycles with no item taken; the reset sweep is the longest lawful wait
  always @(posedge clk) begin
    if (start && !busy) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: files.f
src/ptma_pkg.sv
src/ptma_table.sv
src/ptma_pool.sv
src/page_table_map_allocate.sv
test/tb_page_table_map_allocate.sv
